[rtl/core/integer_alu_with_power_macros.svh]
// Assertion macros for the integer ALU with power.
// Used by the top level only; needs nothing else.
`ifndef INTEGER_ALU_WITH_POWER_MACROS_SVH
`define INTEGER_ALU_WITH_POWER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IALU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ialu_pkg.sv]
// Shared types and constants for the integer ALU with power.
// No dependencies.
`timescale 1ns / 1ps

package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    // Widest slice of the second multiplier operand handled per cycle.
    localparam int MUL_CHUNK_MAX  = 32;

    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POW = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEG_EXP  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [FIELD_W-1:0] op_a;
        logic signed [FIELD_W-1:0] op_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [FIELD_W-1:0] result;
        logic [STATUS_W-1:0]       status;
    } t_out_beat;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_status;

endpackage

[rtl/core/ialu_unit.sv]
// Shared arithmetic unit: one adder/subtractor fed either directly or by a
// multiplier slice (full operand times one chunk). Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_unit #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF,
    parameter int CHUNK_W    = ialu_pkg::MUL_CHUNK_MAX
) (
    input  logic [DATA_WIDTH-1:0] i_add_x,
    input  logic [DATA_WIDTH-1:0] i_add_y,
    input  logic                  i_sub,
    input  logic                  i_use_prod,
    input  logic [DATA_WIDTH-1:0] i_mul_x,
    input  logic [CHUNK_W-1:0]    i_mul_y,
    output logic [DATA_WIDTH-1:0] o_sum,
    output logic                  o_cout
);

    logic [DATA_WIDTH-1:0] prod;
    logic [DATA_WIDTH-1:0] y_sel;
    logic [DATA_WIDTH-1:0] y_eff;
    logic [DATA_WIDTH:0]   full;

    // Only the low word of the product is kept (wrapping arithmetic).
    assign prod  = i_mul_x * DATA_WIDTH'(i_mul_y);
    assign y_sel = i_use_prod ? prod : i_add_y;
    assign y_eff = i_sub ? ~y_sel : y_sel;
    assign full  = {1'b0, i_add_x} + {1'b0, y_eff} + (DATA_WIDTH + 1)'(i_sub);

    // On subtract, carry out high means x >= y.
    assign o_sum  = full[DATA_WIDTH-1:0];
    assign o_cout = full[DATA_WIDTH];

endmodule

[rtl/core/ialu_seq.sv]
// Sequencer and working registers of the integer ALU with power: drives the
// shared unit for multiply, restoring divide and square-and-multiply.
// Depends on ialu_pkg and ialu_unit.
`timescale 1ns / 1ps

module ialu_seq #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ialu_pkg::CMD_W-1:0]     i_cmd,
    input  logic [DATA_WIDTH-1:0]          i_op_a,
    input  logic [DATA_WIDTH-1:0]          i_op_b,
    input  logic                           i_take,
    output ialu_pkg::t_seq_status          o_status,
    output logic [DATA_WIDTH-1:0]          o_result,
    output logic [ialu_pkg::STATUS_W-1:0]  o_code
);

    localparam int DW   = DATA_WIDTH;
    localparam int CW   = (DW < ialu_pkg::MUL_CHUNK_MAX) ? DW : ialu_pkg::MUL_CHUNK_MAX;
    localparam int NCH  = (DW + CW - 1) / CW;
    localparam int CNTW = $clog2(DW);
    localparam logic [CNTW-1:0] MUL_LAST = CNTW'(NCH - 1);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(DW - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_MUL  = 7'b000_0010,
        S_DIV  = 7'b000_0100,
        S_FIX  = 7'b000_1000,
        S_PMUL = 7'b001_0000,
        S_PSQ  = 7'b010_0000,
        S_DONE = 7'b100_0000
    } t_state;

    t_state r_state, n_state;

    // Multiply: r_ma shifts left, r_mb right, r_mp accumulates.
    // Divide: r_ma dividend in / quotient out, r_mb divisor, r_mp remainder.
    logic [DW-1:0] r_ma, n_ma;
    logic [DW-1:0] r_mb, n_mb;
    logic [DW-1:0] r_mp, n_mp;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_pacc, n_pacc;
    logic [DW-1:0] r_base, n_base;
    logic [DW-1:0] r_exp, n_exp;
    logic [DW-1:0] r_res, n_res;
    logic [ialu_pkg::STATUS_W-1:0] r_code, n_code;
    logic r_is_div, n_is_div;
    logic r_neg, n_neg;

    logic [DW-1:0] u_add_x, u_add_y, u_mul_x, u_sum;
    logic [CW-1:0] u_mul_y;
    logic          u_sub, u_use_prod, u_cout;

    logic          a_sign, b_sign;
    logic [DW-1:0] a_mag, b_mag;
    logic [DW-1:0] div_sh;
    logic [DW-1:0] fix_val;
    logic          mul_last;

    assign a_sign   = i_op_a[DW-1];
    assign b_sign   = i_op_b[DW-1];
    assign a_mag    = a_sign ? (DW'(0) - i_op_a) : i_op_a;
    assign b_mag    = b_sign ? (DW'(0) - i_op_b) : i_op_b;
    assign div_sh   = {r_mp[DW-2:0], r_ma[DW-1]};
    assign fix_val  = r_is_div ? r_ma : r_mp;
    assign mul_last = (r_cnt == MUL_LAST);

    ialu_unit #(
        .DATA_WIDTH (DW),
        .CHUNK_W    (CW)
    ) u_unit (
        .i_add_x    (u_add_x),
        .i_add_y    (u_add_y),
        .i_sub      (u_sub),
        .i_use_prod (u_use_prod),
        .i_mul_x    (u_mul_x),
        .i_mul_y    (u_mul_y),
        .o_sum      (u_sum),
        .o_cout     (u_cout)
    );

    // Operand routing into the shared unit. Idle: add/sub straight from input.
    always_comb begin
        u_add_x    = i_op_a;
        u_add_y    = i_op_b;
        u_sub      = (i_cmd == ialu_pkg::CMD_SUB);
        u_use_prod = 1'b0;
        u_mul_x    = r_ma;
        u_mul_y    = r_mb[CW-1:0];
        unique case (r_state) inside
            S_MUL, S_PMUL, S_PSQ: begin
                u_add_x    = r_mp;
                u_add_y    = '0;
                u_sub      = 1'b0;
                u_use_prod = 1'b1;
            end
            S_DIV: begin
                u_add_x = div_sh;
                u_add_y = r_mb;
                u_sub   = 1'b1;
            end
            S_FIX: begin
                u_add_x = '0;
                u_add_y = fix_val;
                u_sub   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_mp     = r_mp;
        n_cnt    = r_cnt;
        n_pacc   = r_pacc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_res    = r_res;
        n_code   = r_code;
        n_is_div = r_is_div;
        n_neg    = r_neg;

        // One multiplier chunk per cycle; overridden below when a product ends.
        if (r_state == S_MUL || r_state == S_PMUL || r_state == S_PSQ) begin
            n_mp  = u_sum;
            n_ma  = r_ma << CW;
            n_mb  = r_mb >> CW;
            n_cnt = r_cnt + CNTW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cnt  = '0;
                    n_mp   = '0;
                    n_res  = '0;
                    n_code = ialu_pkg::ST_OK;
                    case (i_cmd) inside
                        ialu_pkg::CMD_ADD, ialu_pkg::CMD_SUB: begin
                            n_res   = u_sum;
                            n_state = S_DONE;
                        end
                        ialu_pkg::CMD_MUL: begin
                            n_ma    = i_op_a;
                            n_mb    = i_op_b;
                            n_state = S_MUL;
                        end
                        ialu_pkg::CMD_DIV, ialu_pkg::CMD_MOD: begin
                            if (i_op_b == '0) begin
                                n_code  = ialu_pkg::ST_DIV_ZERO;
                                n_state = S_DONE;
                            end else begin
                                n_ma     = a_mag;
                                n_mb     = b_mag;
                                n_is_div = (i_cmd == ialu_pkg::CMD_DIV);
                                n_neg    = (i_cmd == ialu_pkg::CMD_DIV) ?
                                           (a_sign ^ b_sign) : a_sign;
                                n_state  = S_DIV;
                            end
                        end
                        ialu_pkg::CMD_POW: begin
                            if (b_sign) begin
                                n_code  = ialu_pkg::ST_NEG_EXP;
                                n_state = S_DONE;
                            end else if (i_op_b == '0) begin
                                n_res   = DW'(1);
                                n_state = S_DONE;
                            end else begin
                                n_pacc = DW'(1);
                                n_base = i_op_a;
                                n_exp  = i_op_b;
                                if (i_op_b[0]) begin
                                    n_ma    = DW'(1);
                                    n_mb    = i_op_a;
                                    n_state = S_PMUL;
                                end else begin
                                    n_ma    = i_op_a;
                                    n_mb    = i_op_a;
                                    n_state = S_PSQ;
                                end
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (mul_last) begin
                    n_res   = u_sum;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + CNTW'(1);
                n_mp  = u_cout ? u_sum : div_sh;
                n_ma  = {r_ma[DW-2:0], u_cout};
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_res   = r_neg ? u_sum : fix_val;
                n_state = S_DONE;
            end
            S_PMUL: begin
                if (mul_last) begin
                    n_pacc = u_sum;
                    // Last set bit of the exponent: skip the final squaring.
                    if (r_exp[DW-1:1] == '0) begin
                        n_res   = u_sum;
                        n_state = S_DONE;
                    end else begin
                        n_ma    = r_base;
                        n_mb    = r_base;
                        n_mp    = '0;
                        n_cnt   = '0;
                        n_state = S_PSQ;
                    end
                end
            end
            S_PSQ: begin
                if (mul_last) begin
                    n_base = u_sum;
                    n_exp  = r_exp >> 1;
                    n_mp   = '0;
                    n_cnt  = '0;
                    if (r_exp[1]) begin
                        n_ma    = r_pacc;
                        n_mb    = u_sum;
                        n_state = S_PMUL;
                    end else begin
                        n_ma    = u_sum;
                        n_mb    = u_sum;
                        n_state = S_PSQ;
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_mp     <= n_mp;
        r_cnt    <= n_cnt;
        r_pacc   <= n_pacc;
        r_base   <= n_base;
        r_exp    <= n_exp;
        r_res    <= n_res;
        r_code   <= n_code;
        r_is_div <= n_is_div;
        r_neg    <= n_neg;
    end

    assign o_status.idle = (r_state == S_IDLE);
    assign o_status.done = (r_state == S_DONE);
    assign o_result      = r_res;
    assign o_code        = r_code;

endmodule

[rtl/core/integer_alu_with_power.sv]
// Integer ALU with power: add, subtract, multiply, divide, remainder and power
// on two's complement operands, wrapping at DATA_WIDTH bits, one result beat per
// input beat. Items are handled one at a time; the input stalls from acceptance
// until the sequencer hands its result to the output register, which can hold a
// finished beat while the next item is taken. Add, subtract, unused codes, zero
// divisor and negative or zero exponent go straight to the result; multiply runs
// NCH = ceil(DATA_WIDTH/32) multiplier chunks; divide and remainder take one
// restoring step per cycle, then a sign fix; power runs one square per exponent
// bit below the top set bit plus one multiply per set bit, each a full product.
// All of it runs through one shared adder fed by a DATA_WIDTH x CW multiplier
// slice, CW = min(DATA_WIDTH, 32). Quotients truncate toward zero, remainders
// follow the dividend's sign, x/0 gives status 1, a negative exponent status 2,
// both with result 0. Operands are zero-extended or truncated to DATA_WIDTH.
// Depends on ialu_pkg, ialu_seq, ialu_unit and the macros header.
`timescale 1ns / 1ps

`include "integer_alu_with_power_macros.svh"

module integer_alu_with_power #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ialu_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ialu_pkg::t_out_beat o_out_data
);

    ialu_pkg::t_seq_status         seq_st;
    logic [DATA_WIDTH-1:0]         seq_res;
    logic [ialu_pkg::STATUS_W-1:0] seq_code;
    logic                          start;
    logic                          take;

    logic                r_out_valid, n_out_valid;
    ialu_pkg::t_out_beat r_out_data, n_out_data;

    assign start = i_in_valid && seq_st.idle;
    // Output register free, or its beat leaves this cycle.
    assign take  = seq_st.done && (!r_out_valid || !i_out_stall);

    ialu_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_in_data.cmd),
        .i_op_a   (DATA_WIDTH'($unsigned(i_in_data.op_a))),
        .i_op_b   (DATA_WIDTH'($unsigned(i_in_data.op_b))),
        .i_take   (take),
        .o_status (seq_st),
        .o_result (seq_res),
        .o_code   (seq_code)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (take) begin
            n_out_valid       = 1'b1;
            n_out_data.result = ialu_pkg::FIELD_W'(seq_res);
            n_out_data.status = seq_code;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = !seq_st.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `IALU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start, !seq_st.idle, "sequencer idle right after an accepted beat")
    `IALU_ASSERT_NEXT(a_idle_after_take, i_clk, i_rst_n, take, seq_st.idle && r_out_valid, "result handoff did not free the sequencer")
    `IALU_ASSERT_SAME(a_error_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ialu_pkg::ST_OK), o_out_data.result == '0, "error beat with nonzero result")

endmodule
